/* rtl/rrtt_pkg.sv */
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared types and constants for the round-robin task table.
// ----------------------------------------------------------------------------
package rrtt_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam logic [31:0] ADOPTIVE_PID = 32'd1;
  localparam int IN_W  = 72;
  localparam int OUT_W = 136;

  typedef logic [2:0] op_t;
  localparam op_t OP_CREATE  = 3'd0;
  localparam op_t OP_DESTROY = 3'd1;
  localparam op_t OP_SCHED   = 3'd2;
  localparam op_t OP_SWITCH  = 3'd3;
  localparam op_t OP_EXIT    = 3'd4;
  localparam op_t OP_FIND    = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_MISS    = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_NO_CUR  = 2'd3;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_READY   = 2'd0;
  localparam mode_t MODE_RUNNING = 2'd1;
  localparam mode_t MODE_ZOMBIE  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_SCAN_NEXT,
    CMD_CREATE,
    CMD_WALK_HEAD,
    CMD_STEP,
    CMD_DESTROY,
    CMD_SWITCH,
    CMD_FIND,
    CMD_EXIT_MARK,
    CMD_REPARENT,
    CMD_SCHED_START,
    CMD_SCHED_SELF,
    CMD_MAKE_CUR,
    CMD_OUT
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t  cmd;
    logic    set_status;
    status_t status;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic runnable;
    logic wrap;
    logic free;
    logic last_slot;
    logic present;
    logic nonempty;
    logic is_cur;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/rrtt_ctrl.sv */
// ----------------------------------------------------------------------------
// rrtt_ctrl
// Operation sequencer: dispatch, ring walks and result hand-off.
// ----------------------------------------------------------------------------
module rrtt_ctrl #(
  parameter int MAX_TASKS = rrtt_pkg::MAX_TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rrtt_pkg::dp_sts_t   sts,
  output rrtt_pkg::ctrl_cmd_t cmd
);
  import rrtt_pkg::*;

  localparam int NW = $clog2(MAX_TASKS);
  localparam logic [NW-1:0] N_LAST = NW'(MAX_TASKS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_LOOK, S_REP_INIT, S_REPARENT,
    S_SCHED_ENTRY, S_SCHED, S_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [NW-1:0] n_r, n_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    cmd       = '{cmd: CMD_NONE, set_status: 1'b0, status: ST_OK};
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cmd   = CMD_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        n_nxt = '0;
        case (sts.op)
          OP_CREATE: state_nxt = S_SCAN;
          OP_DESTROY, OP_SWITCH, OP_FIND: begin
            if (!sts.nonempty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_MISS;
              state_nxt      = S_FINISH;
            end else begin
              cmd.cmd   = CMD_WALK_HEAD;
              state_nxt = S_LOOK;
            end
          end
          OP_SCHED: state_nxt = S_SCHED_ENTRY;
          OP_EXIT: begin
            if (!sts.present) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NO_CUR;
              state_nxt      = S_FINISH;
            end else begin
              cmd.cmd   = CMD_EXIT_MARK;
              state_nxt = S_REP_INIT;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (sts.free) begin
          cmd.cmd   = CMD_CREATE;
          state_nxt = S_FINISH;
        end else if (sts.last_slot) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_nxt      = S_FINISH;
        end else begin
          cmd.cmd = CMD_SCAN_NEXT;
        end
      end
      S_LOOK: begin
        if (sts.hit) begin
          case (sts.op)
            OP_DESTROY: cmd.cmd = CMD_DESTROY;
            OP_SWITCH:  cmd.cmd = CMD_SWITCH;
            default:    cmd.cmd = CMD_FIND;
          endcase
          state_nxt = S_FINISH;
        end else if (sts.wrap || n_r == N_LAST) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_MISS;
          state_nxt      = S_FINISH;
        end else begin
          cmd.cmd = CMD_STEP;
          n_nxt   = n_r + 1'b1;
        end
      end
      S_REP_INIT: begin
        n_nxt = '0;
        if (sts.nonempty) begin
          cmd.cmd   = CMD_WALK_HEAD;
          state_nxt = S_REPARENT;
        end else begin
          state_nxt = S_SCHED_ENTRY;
        end
      end
      S_REPARENT: begin
        cmd.cmd = CMD_REPARENT;
        if (sts.wrap || n_r == N_LAST) state_nxt = S_SCHED_ENTRY;
        else n_nxt = n_r + 1'b1;
      end
      S_SCHED_ENTRY: begin
        n_nxt = '0;
        if (sts.nonempty) begin
          cmd.cmd   = CMD_SCHED_START;
          state_nxt = S_SCHED;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCHED: begin
        if (sts.runnable) begin
          cmd.cmd   = (sts.present && sts.is_cur) ? CMD_SCHED_SELF : CMD_MAKE_CUR;
          state_nxt = S_FINISH;
        end else if (n_r == N_LAST) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.cmd = CMD_STEP;
          n_nxt   = n_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.cmd   = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule

/* rtl/rrtt_dp.sv */
// ----------------------------------------------------------------------------
// rrtt_dp
// Task slot tables, ring links, walk pointer and result register.
// ----------------------------------------------------------------------------
module rrtt_dp #(
  parameter int MAX_TASKS = rrtt_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rrtt_pkg::IN_W-1:0]   in_tdata,
  input  rrtt_pkg::ctrl_cmd_t         cmd,
  output rrtt_pkg::dp_sts_t           sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rrtt_pkg::OUT_W-1:0]  out_tdata
);
  import rrtt_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  typedef logic [IW-1:0] idx_t;

  logic        used_r   [MAX_TASKS];
  logic [31:0] pid_r    [MAX_TASKS];
  logic [31:0] parent_r [MAX_TASKS];
  mode_t       mode_r   [MAX_TASKS];
  logic [31:0] code_r   [MAX_TASKS];
  idx_t        next_r   [MAX_TASKS];
  idx_t        prev_r   [MAX_TASKS];
  idx_t        head_r, cur_r, s_r;
  logic        nonempty_r, present_r;
  logic [31:0] ctr_r;

  op_t         op_r;
  logic [31:0] tpid_r, xval_r, me_r;
  status_t     status_r;
  logic [31:0] rpid_r, fparent_r, fexit_r;
  mode_t       fstate_r;
  logic        sw_r;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  idx_t        nx, pv, tail;
  logic [31:0] run_pid;

  assign nx      = next_r[s_r];
  assign pv      = prev_r[s_r];
  assign tail    = prev_r[head_r];
  assign run_pid = present_r ? pid_r[cur_r] : 32'd0;

  assign sts.op        = op_r;
  assign sts.hit       = (pid_r[s_r] == tpid_r);
  assign sts.runnable  = (mode_r[s_r] == MODE_READY) || (mode_r[s_r] == MODE_RUNNING);
  assign sts.wrap      = (nx == head_r);
  assign sts.free      = !used_r[s_r];
  assign sts.last_slot = (s_r == IW'(MAX_TASKS - 1));
  assign sts.present   = present_r;
  assign sts.nonempty  = nonempty_r;
  assign sts.is_cur    = (s_r == cur_r);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        used_r[i]   <= 1'b0;
        pid_r[i]    <= 32'd0;
        parent_r[i] <= 32'd0;
        mode_r[i]   <= MODE_READY;
        code_r[i]   <= 32'd0;
        next_r[i]   <= '0;
        prev_r[i]   <= '0;
      end
      used_r[0]   <= 1'b1;
      used_r[1]   <= 1'b1;
      pid_r[0]    <= 32'd1;
      pid_r[1]    <= 32'd2;
      mode_r[1]   <= MODE_RUNNING;
      next_r[0]   <= IW'(1);
      prev_r[0]   <= IW'(1);
      head_r      <= IW'(1);
      cur_r       <= IW'(1);
      s_r         <= '0;
      nonempty_r  <= 1'b1;
      present_r   <= 1'b1;
      ctr_r       <= 32'd3;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cmd == CMD_OUT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cmd.set_status) status_r <= cmd.status;
      case (cmd.cmd)
        CMD_LATCH: begin
          op_r      <= in_tdata[2:0];
          tpid_r    <= in_tdata[34:3];
          xval_r    <= in_tdata[66:35];
          s_r       <= '0;
          status_r  <= ST_OK;
          rpid_r    <= 32'd0;
          sw_r      <= 1'b0;
          fstate_r  <= MODE_READY;
          fparent_r <= 32'd0;
          fexit_r   <= 32'd0;
        end
        CMD_SCAN_NEXT: s_r <= s_r + 1'b1;
        CMD_CREATE: begin
          used_r[s_r]   <= 1'b1;
          pid_r[s_r]    <= ctr_r;
          ctr_r         <= ctr_r + 32'd1;
          parent_r[s_r] <= run_pid;
          mode_r[s_r]   <= MODE_READY;
          code_r[s_r]   <= 32'd0;
          rpid_r        <= ctr_r;
          if (!nonempty_r) begin
            head_r      <= s_r;
            next_r[s_r] <= s_r;
            prev_r[s_r] <= s_r;
            nonempty_r  <= 1'b1;
          end else begin
            next_r[tail]   <= s_r;
            prev_r[s_r]    <= tail;
            next_r[s_r]    <= head_r;
            prev_r[head_r] <= s_r;
          end
        end
        CMD_WALK_HEAD: s_r <= head_r;
        CMD_STEP:      s_r <= nx;
        CMD_DESTROY: begin
          next_r[s_r] <= '0;
          prev_r[s_r] <= '0;
          if (nx == s_r) begin
            nonempty_r <= 1'b0;
          end else begin
            next_r[pv] <= nx;
            prev_r[nx] <= pv;
            if (head_r == s_r) head_r <= nx;
          end
          used_r[s_r] <= 1'b0;
          if (present_r && cur_r == s_r) begin
            present_r <= 1'b0;
            sw_r      <= 1'b1;
          end
        end
        CMD_SWITCH, CMD_MAKE_CUR: begin
          if (!(cmd.cmd == CMD_SWITCH && present_r && cur_r == s_r)) begin
            if (present_r && mode_r[cur_r] == MODE_RUNNING) mode_r[cur_r] <= MODE_READY;
            mode_r[s_r] <= MODE_RUNNING;
            cur_r       <= s_r;
            present_r   <= 1'b1;
            sw_r        <= 1'b1;
          end
        end
        CMD_FIND: begin
          rpid_r    <= pid_r[s_r];
          fstate_r  <= mode_r[s_r];
          fparent_r <= parent_r[s_r];
          fexit_r   <= code_r[s_r];
        end
        CMD_EXIT_MARK: begin
          code_r[cur_r] <= xval_r;
          mode_r[cur_r] <= MODE_ZOMBIE;
          me_r          <= pid_r[cur_r];
        end
        CMD_REPARENT: begin
          if (parent_r[s_r] == me_r) parent_r[s_r] <= ADOPTIVE_PID;
          s_r <= nx;
        end
        CMD_SCHED_START: s_r <= present_r ? next_r[cur_r] : head_r;
        CMD_SCHED_SELF:  mode_r[s_r] <= MODE_RUNNING;
        CMD_OUT: begin
          out_data_r  <= {3'b000, fexit_r, fparent_r, fstate_r, sw_r, run_pid,
                          rpid_r, status_r};
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/round_robin_task_table.sv */
// ----------------------------------------------------------------------------
// round_robin_task_table
// Task table with a circular task ring: create, destroy, schedule, switch,
// exit and find operations, one result word per input word.
// ----------------------------------------------------------------------------
// Walks: ring walks and the create slot scan visit one entry per cycle in
//   the sequencer's walk loop.
// Throughput: one word at a time; next word accepted once the result is
//   handed to the output register.
// Reset: synchronous active-low; idle pid 1 ready, boot pid 2 running.
// ----------------------------------------------------------------------------
module round_robin_task_table #(
  parameter int MAX_TASKS = rrtt_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // op[2:0], target_pid[34:3], exit_value[66:35], zero fill
  input  logic [rrtt_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status[1:0], result_pid[33:2], running_pid[65:34], switched[66],
  // found_state[68:67], found_parent[100:69], found_exit[132:101], zero fill
  output logic [rrtt_pkg::OUT_W-1:0]  out_tdata
);
  import rrtt_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  rrtt_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrtt_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
